/* rtl/psmc_pkg.sv */
// Package: shared constants and payload types of the pivot search corner block
`default_nettype none
package psmc_pkg;
   localparam int MAX_INTERP = 5;
   localparam int MAX_PIVOTS = 64;
   localparam int DIV_STEPS  = 16;
   localparam int ICNT_W     = 3;
   localparam int CNT_W      = 6;
   localparam logic [15:0] TOL_RESET = 16'd7;

   typedef struct packed {
      logic signed [31:0] param_value;
      logic signed [31:0] pivot_value;
      logic               pivot_last;
      logic               param_last;
   } in_type;

   typedef struct packed {
      logic              kind;
      logic [15:0]       corner_index;
      logic [15:0]       blend_t;
      logic              out_of_range;
      logic              overflow;
      logic [ICNT_W-1:0] interp_count;
      logic              last;
   } out_type;

   typedef struct packed {
      logic             search;
      logic             div_step;
      logic             finish;
      logic             scan;
      logic             emit;
      logic             emit_last;
      logic [CNT_W-1:0] index;
   } cmd_type;

   typedef struct packed {
      logic              need_div;
      logic              out_free;
      logic [ICNT_W-1:0] icount;
   } status_type;
endpackage
`default_nettype wire

/* rtl/psmc_ctrl.sv */
// Controller: sequences search, divide, finish, corner scan and emission
`default_nettype none
module psmc_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       pivot_last,
   input  wire                       param_last,
   output logic                      req_stall,
   input  wire psmc_pkg::status_type status,
   output psmc_pkg::cmd_type         cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [psmc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic plast_ff, plast_in, lastp_ff, lastp_in;
   logic [psmc_pkg::CNT_W-1:0] corners, total;
   logic accept;

   assign corners   = psmc_pkg::CNT_W'(1) << status.icount;
   assign total     = corners + psmc_pkg::CNT_W'(status.icount);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      plast_in = plast_ff;
      lastp_in = lastp_ff;
      cmd      = '0;
      cmd.index = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.search = 1'b1;
               plast_in   = pivot_last;
               lastp_in   = param_last;
               cnt_in     = '0;
               if (status.need_div) state_in = S_DIV;
               else if (pivot_last) state_in = S_FIN;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == psmc_pkg::CNT_W'(psmc_pkg::DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = plast_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            cnt_in     = '0;
            state_in   = lastp_ff ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == corners - 1'b1) begin
               cnt_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff == total - 1'b1) begin
                  cmd.emit_last = 1'b1;
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         plast_ff <= 1'b0;
         lastp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         plast_ff <= plast_in;
         lastp_ff <= lastp_in;
      end
   end

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < psmc_pkg::CNT_W'(psmc_pkg::DIV_STEPS)))
      else $error("divide step count out of range");
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (state_ff == S_IDLE))
      else $error("emission did not end");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> req_stall)
      else $error("input taken during scan");
endmodule
`default_nettype wire

/* rtl/psmc_datapath.sv */
// Datapath: pivot search, serial divider, index state, corner sums and output register
`default_nettype none
module psmc_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [15:0]           tolerance,
   input  wire psmc_pkg::in_type req_data,
   input  wire                   rsp_stall,
   output logic                  rsp_valid,
   output psmc_pkg::out_type     rsp_data,
   input  wire psmc_pkg::cmd_type cmd,
   output psmc_pkg::status_type  status
);
   localparam int IW = psmc_pkg::ICNT_W;

   logic signed [31:0] prev_ff, prev_in;
   logic decided_ff, decided_in;
   logic [7:0] seg_ff, seg_in, pcnt_ff, pcnt_in;
   logic [15:0] base_ff, base_in, stride_ff, stride_in;
   logic [IW-1:0] icnt_ff, icnt_in;
   logic [15:0] strides_ff [psmc_pkg::MAX_INTERP];
   logic [15:0] blends_ff  [psmc_pkg::MAX_INTERP];
   logic clamp_ff, clamp_in, ovf_ff, ovf_in, sint_ff, sint_in;
   logic [33:0] rem_ff, rem_in, den_ff, den_in;
   logic [15:0] q_ff, q_in;
   logic out_valid_ff, out_valid_in;
   psmc_pkg::out_type out_ff, out_in;
   logic wr_interp;

   logic signed [33:0] p34, pv34, tol34, lo, hi, prev34, num, den;
   logic in_range, single, need_div;
   logic [33:0] r2;
   logic [7:0] seg_eff;
   logic [23:0] seg_prod, str_prod;
   logic [24:0] base_sum;
   logic [18:0] csum;
   logic [psmc_pkg::CNT_W-1:0] corners, bidx;
   logic [psmc_pkg::MAX_INTERP-1:0] kbits;

   assign p34    = {{2{req_data.param_value[31]}}, req_data.param_value};
   assign pv34   = {{2{req_data.pivot_value[31]}}, req_data.pivot_value};
   assign tol34  = {18'd0, tolerance};
   assign prev34 = {{2{prev_ff[31]}}, prev_ff};
   assign lo     = pv34 - tol34;
   assign hi     = pv34 + tol34;
   assign num    = p34 - prev34;
   assign den    = pv34 - prev34;
   assign in_range = (pcnt_ff < 8'(psmc_pkg::MAX_PIVOTS));
   assign single   = req_data.pivot_last && (pcnt_ff == 8'd0);
   assign need_div = in_range && !decided_ff && (pcnt_ff != 8'd0) && (p34 < hi)
                     && !(lo < p34) && (num > 0) && (den > 0);
   assign r2 = {rem_ff[32:0], 1'b0};

   assign seg_eff  = decided_ff ? seg_ff : ((pcnt_ff != 8'd0) ? pcnt_ff - 8'd1 : 8'd0);
   assign seg_prod = seg_eff * stride_ff;
   assign str_prod = stride_ff * pcnt_ff;
   assign base_sum = 25'(base_ff) + 25'(seg_prod);

   assign corners = psmc_pkg::CNT_W'(1) << icnt_ff;
   assign kbits   = cmd.index[psmc_pkg::MAX_INTERP-1:0];
   assign bidx    = cmd.index - corners;

   always_comb begin
      csum = 19'(base_ff);
      for (int b = 0; b < psmc_pkg::MAX_INTERP; b++) begin
         if (kbits[b]) csum = csum + 19'(strides_ff[b]);
      end
   end

   assign status.need_div = need_div;
   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign status.icount   = icnt_ff;

   always_comb begin
      prev_in = prev_ff; decided_in = decided_ff; seg_in = seg_ff; pcnt_in = pcnt_ff;
      base_in = base_ff; stride_in = stride_ff; icnt_in = icnt_ff;
      clamp_in = clamp_ff; ovf_in = ovf_ff; sint_in = sint_ff;
      rem_in = rem_ff; den_in = den_ff; q_in = q_ff;
      out_in = out_ff; wr_interp = 1'b0;
      out_valid_in = rsp_stall ? out_valid_ff : 1'b0;
      if (cmd.search) begin
         if (in_range) begin
            pcnt_in = pcnt_ff + 8'd1;
            prev_in = req_data.pivot_value;
            if (!decided_ff) begin
               if (pcnt_ff == 8'd0) begin
                  if (single) begin
                     if (!(lo < p34 && p34 < hi)) clamp_in = 1'b1;
                     seg_in = 8'd0; decided_in = 1'b1;
                  end else if (p34 < lo) begin
                     seg_in = 8'd0; clamp_in = 1'b1; decided_in = 1'b1;
                  end else if (p34 < hi) begin
                     seg_in = 8'd0; decided_in = 1'b1;
                  end
               end else if (p34 < hi) begin
                  decided_in = 1'b1;
                  if (lo < p34) begin
                     seg_in = pcnt_ff;
                  end else begin
                     seg_in  = pcnt_ff - 8'd1;
                     sint_in = 1'b1;
                     q_in    = 16'd0;
                     rem_in  = 34'(num);
                     den_in  = 34'(den);
                  end
               end
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.div_step) begin
         if (r2 >= den_ff) begin
            rem_in = r2 - den_ff;
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = r2;
            q_in   = {q_ff[14:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         if (!decided_ff) clamp_in = 1'b1;
         if (sint_ff) begin
            if (icnt_ff < IW'(psmc_pkg::MAX_INTERP)) begin
               wr_interp = 1'b1;
               icnt_in   = icnt_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         if (base_sum[24:16] != 9'd0 || str_prod[23:16] != 8'd0) ovf_in = 1'b1;
         base_in   = base_sum[15:0];
         stride_in = str_prod[15:0];
         prev_in = '0; decided_in = 1'b0; seg_in = '0; pcnt_in = '0; sint_in = 1'b0;
      end
      if (cmd.scan) begin
         if (csum[18:16] != 3'd0) ovf_in = 1'b1;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_in.out_of_range = clamp_ff;
         out_in.overflow     = ovf_ff;
         out_in.interp_count = icnt_ff;
         out_in.last         = cmd.emit_last;
         if (cmd.index < corners) begin
            out_in.kind         = 1'b0;
            out_in.corner_index = csum[15:0];
            out_in.blend_t      = 16'd0;
         end else begin
            out_in.kind         = 1'b1;
            out_in.corner_index = 16'd0;
            out_in.blend_t      = blends_ff[bidx[IW-1:0]];
         end
         if (cmd.emit_last) begin
            base_in = '0; stride_in = 16'd1; icnt_in = '0;
            clamp_in = 1'b0; ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0; decided_ff <= 1'b0; seg_ff <= '0; pcnt_ff <= '0;
         base_ff <= '0; stride_ff <= 16'd1; icnt_ff <= '0;
         clamp_ff <= 1'b0; ovf_ff <= 1'b0; sint_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in; decided_ff <= decided_in; seg_ff <= seg_in; pcnt_ff <= pcnt_in;
         base_ff <= base_in; stride_ff <= stride_in; icnt_ff <= icnt_in;
         clamp_ff <= clamp_in; ovf_ff <= ovf_in; sint_ff <= sint_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      out_ff <= out_in;
      if (wr_interp) begin
         strides_ff[icnt_ff] <= stride_ff;
         blends_ff[icnt_ff]  <= q_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_icnt: assert property (@(posedge clock) disable iff (reset)
      icnt_ff <= IW'(psmc_pkg::MAX_INTERP))
      else $error("interpolation count past limit");
   a_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (icnt_ff == '0 && base_ff == 16'd0 && !ovf_ff && !clamp_ff))
      else $error("set state not cleared after emission");
   a_pcnt: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= 8'(psmc_pkg::MAX_PIVOTS))
      else $error("pivot count past limit");
endmodule
`default_nettype wire

/* rtl/pivot_search_multilinear_corners_top.sv */
// Top level: pivot search with multilinear corner indexing, register port and channels
//
// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     psmc_pkg::in_type
// rsp_      out        rsp_valid / rsp_stall     psmc_pkg::out_type
// csr       in/out     psel penable pwrite pready tolerance at byte address 0
//
// A pivot transaction is taken while idle; a pivot that opens a segment with the value
// above its lower pivot adds a divide of a 16-bit quotient (one quotient bit per cycle
// in the serial divider), and a last pivot adds a finish step. After the last parameter,
// the scan checks the 2^n corner sums for overflow, then 2^n + n result transactions
// leave at one per cycle while rsp_stall is low.
// Reset is synchronous and clears all control state; tolerance returns to 7.
`default_nettype none
module pivot_search_multilinear_corners_top (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire psmc_pkg::in_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output psmc_pkg::out_type     rsp_data,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [2:0]            paddr,
   input  wire  [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   logic [15:0] tol_ff, tol_in;
   psmc_pkg::cmd_type    cmd;
   psmc_pkg::status_type status;

   assign pready = 1'b1;
   assign tol_in = (psel && penable && pwrite && paddr[2] == 1'b0) ? pwdata[15:0] : tol_ff;
   assign prdata = (paddr[2] == 1'b0) ? {16'd0, tol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= psmc_pkg::TOL_RESET;
      else       tol_ff <= tol_in;
   end

   psmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .pivot_last (req_data.pivot_last),
      .param_last (req_data.param_last),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   psmc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
`default_nettype wire
